// ===== rtl/fsu_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the feature standardizer.
package fsu_pkg;

  // Default sample capacity and fixed feature limit
  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned MAX_DIMS        = 16;

  // Field widths
  localparam int unsigned DATA_W = 16;
  localparam int unsigned FIDX_W = 4;
  localparam int unsigned DIMS_W = 5;
  localparam int unsigned CMD_W  = 2;

  // Divider geometry: 64-bit dividend, 32-bit divisor
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DVS_W = 32;

  // |d|^2 scaled by 4 * 4096^2 before the divide
  localparam int unsigned NORM_SHIFT = 26;

  // Rounded square root result
  localparam int unsigned ROOT_W = 16;
  localparam int unsigned ROOT_BIT_W = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Register indexes
  localparam logic REG_REFIT = 1'b0;
  localparam logic REG_DIMS  = 1'b1;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_DIV_CNT,
    OP_TAKE_N,
    OP_WALK_INIT,
    OP_RD_WALK,
    OP_ACC_SUM,
    OP_DIV_MEAN,
    OP_TAKE_MEAN,
    OP_DIF,
    OP_SQ,
    OP_ACC_SQ,
    OP_DIV_VAR,
    OP_TAKE_VAR,
    OP_RP_CLR,
    OP_DIV_MOD,
    OP_TAKE_MOD,
    OP_DIV_NORM,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   new_set;
  } fsu_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic i_last;
    logic j_last;
    logic n_zero;
    logic refit;
    logic rp_valid;
    logic var_zero;
    logic sqrt_last;
    logic out_free;
  } fsu_sts_t;

endpackage

// ===== rtl/fsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fsu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module fsu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fsu_pkg::DIV_W-1:0] dividend_i,
  input  logic [fsu_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [fsu_pkg::DIV_W-1:0] quot_o,
  output logic [fsu_pkg::DVS_W-1:0] rem_o
);
  import fsu_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Shift in next dividend bit and trial subtract
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (cnt_q == CNT_W'(DIV_W - 1))) begin
      busy_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/fsu_dp.sv =====
// Datapath: sample memory, statistics, divider, root search and result register.
module fsu_dp #(
  parameter int unsigned MAX_SAMPLES = fsu_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fsu_pkg::fsu_cmd_t                 cmd_i,
  output fsu_pkg::fsu_sts_t                 sts_o,
  input  logic signed [fsu_pkg::DATA_W-1:0] sample_value_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [fsu_pkg::DIMS_W-1:0]        cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [fsu_pkg::DATA_W-1:0] norm_value_o,
  output logic [fsu_pkg::FIDX_W-1:0]        feature_index_o,
  output logic                              last_value_o,
  output logic                              div_zero_o
);
  import fsu_pkg::*;

  localparam int unsigned DEPTH = MAX_SAMPLES * MAX_DIMS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned ACCW  = 2 * DATA_W + CW;
  localparam int unsigned DW1   = DATA_W + 1;
  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b1, {(ROOT_W-1){1'b0}}};
  localparam logic [ROOT_W-1:0] POS_MAX  = {1'b0, {(ROOT_W-1){1'b1}}};

  // Configuration
  logic              refit_q;
  logic [DIMS_W-1:0] dims_q;
  logic [DIMS_W-1:0] dims_eff;

  // Set bookkeeping and statistics
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            rp_q;
  logic [CW-1:0]            n_q;
  logic [CW-1:0]            i_q;
  logic [CW-1:0]            addr_q;
  logic [FIDX_W-1:0]        j_q;
  logic [ACCW-1:0]          acc_q;
  logic signed [DATA_W-1:0] mean_q [MAX_DIMS];
  logic [DVS_W-1:0]         var_q  [MAX_DIMS];
  logic signed [DW1-1:0]    d_q;
  logic [2*DATA_W-1:0]      dsq_q;
  logic [ROOT_W-1:0]        r_q;
  logic [ROOT_BIT_W-1:0]    b_q;

  // Result register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] norm_q;
  logic [FIDX_W-1:0]        fidx_q;
  logic                     last_q;
  logic                     dz_q;

  // Memory and divider hookup
  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic signed [DATA_W-1:0] x;
  logic                     div_start;
  logic [DIV_W-1:0]         div_a;
  logic [DVS_W-1:0]         div_b;
  logic                     div_busy;
  logic [DIV_W-1:0]         div_q;
  logic [DVS_W-1:0]         div_r;

  // Helpers
  logic [CW-1:0]              store_base;
  logic                       store_room;
  logic [ACCW-1:0]            acc_mag;
  logic [DIV_W-1:0]           half_n;
  logic signed [DATA_W-1:0]   mean_rd;
  logic [DVS_W-1:0]           var_rd;
  logic signed [2*DW1-1:0]    prod;
  logic [ROOT_W-1:0]          cand;
  logic [ROOT_W:0]            odd;
  logic [2*ROOT_W+1:0]        odd_sq;
  logic                       cand_fits;
  logic signed [DATA_W-1:0]   norm_d;
  logic [DATA_W-1:0]          mean_mag;

  // Clamp the feature count
  always_comb begin
    if (dims_q == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (dims_q > DIMS_W'(MAX_DIMS)) begin
      dims_eff = DIMS_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_q;
    end
  end

  assign store_base = cmd_i.new_set ? '0 : cnt_q;
  assign store_room = (store_base < CW'(DEPTH));
  assign acc_mag    = acc_q[ACCW-1] ? (~acc_q + ACCW'(1)) : acc_q;
  assign half_n     = DIV_W'(n_q >> 1);
  assign mean_rd    = mean_q[j_q];
  assign var_rd     = var_q[j_q];
  assign prod       = d_q * d_q;
  assign mean_mag   = div_q[DATA_W-1:0];

  // Root search candidate: keep cand when (2*cand-1)^2 <= t
  assign cand      = r_q | (ROOT_W'(1) << b_q);
  assign odd       = {cand, 1'b0} - (ROOT_W+1)'(1);
  assign odd_sq    = odd * odd;
  assign cand_fits = (cand <= ROOT_MAX) && (DIV_W'(odd_sq) <= div_q);

  // Signed, saturated result
  always_comb begin
    if (var_rd == '0) begin
      norm_d = '0;
    end else if (d_q[DW1-1]) begin
      norm_d = -$signed(r_q);
    end else if (r_q > POS_MAX) begin
      norm_d = $signed(POS_MAX);
    end else begin
      norm_d = $signed(r_q);
    end
  end

  // Memory ports
  assign ram_we    = (cmd_i.op == OP_STORE) && store_room;
  assign ram_waddr = store_base[AW-1:0];
  assign ram_re    = (cmd_i.op == OP_RD_WALK) || (cmd_i.op == OP_TAKE_MOD);
  assign ram_raddr = (cmd_i.op == OP_RD_WALK) ? addr_q[AW-1:0] : rp_q[AW-1:0];

  fsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (x)
  );

  // Select divider operands
  always_comb begin
    div_start = 1'b1;
    div_a     = '0;
    div_b     = '0;
    case (cmd_i.op)
      OP_DIV_CNT: begin
        div_a = DIV_W'(cnt_q);
        div_b = DVS_W'(dims_eff);
      end
      OP_DIV_MEAN: begin
        div_a = DIV_W'(acc_mag) + half_n;
        div_b = DVS_W'(n_q);
      end
      OP_DIV_VAR: begin
        div_a = DIV_W'(acc_q) + half_n;
        div_b = DVS_W'(n_q);
      end
      OP_DIV_MOD: begin
        div_a = DIV_W'(rp_q);
        div_b = DVS_W'(dims_eff);
      end
      OP_DIV_NORM: begin
        div_a = DIV_W'({dsq_q, {NORM_SHIFT{1'b0}}});
        div_b = var_rd;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  fsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // State with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refit_q     <= 1'b1;
      dims_q      <= DIMS_W'(2);
      cnt_q       <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        mean_q[k] <= '0;
        var_q[k]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_REFIT) begin
          refit_q <= cfg_data_i[0];
        end else begin
          dims_q <= cfg_data_i;
        end
      end
      // Drop a delivered result, take a new one
      if (cmd_i.op == OP_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_STORE: begin
          cnt_q <= store_room ? (store_base + CW'(1)) : store_base;
          if (cmd_i.new_set) begin
            rp_q <= '0;
          end
        end
        OP_TAKE_N: begin
          cnt_q <= cnt_q - div_r[CW-1:0];
        end
        OP_TAKE_MEAN: begin
          mean_q[j_q] <= acc_q[ACCW-1] ? -$signed(mean_mag) : $signed(mean_mag);
        end
        OP_TAKE_VAR: begin
          var_q[j_q] <= (|div_q[DIV_W-1:DVS_W]) ? '1 : div_q[DVS_W-1:0];
        end
        OP_RP_CLR: begin
          rp_q <= '0;
        end
        OP_LOAD_OUT: begin
          rp_q <= rp_q + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TAKE_N: begin
        n_q <= div_q[CW-1:0];
        j_q <= '0;
      end
      OP_WALK_INIT: begin
        acc_q  <= '0;
        i_q    <= '0;
        addr_q <= CW'(j_q);
      end
      OP_ACC_SUM: begin
        acc_q  <= acc_q + {{(ACCW-DATA_W){x[DATA_W-1]}}, x};
        addr_q <= addr_q + CW'(dims_eff);
        i_q    <= i_q + CW'(1);
      end
      OP_ACC_SQ: begin
        acc_q  <= acc_q + ACCW'(dsq_q);
        addr_q <= addr_q + CW'(dims_eff);
        i_q    <= i_q + CW'(1);
      end
      OP_DIF: begin
        d_q <= DW1'(x) - DW1'(mean_rd);
      end
      OP_SQ: begin
        dsq_q <= prod[2*DATA_W-1:0];
      end
      OP_TAKE_VAR: begin
        j_q <= j_q + FIDX_W'(1);
      end
      OP_TAKE_MOD: begin
        j_q <= div_r[FIDX_W-1:0];
      end
      OP_SQRT_INIT: begin
        r_q <= '0;
        b_q <= ROOT_BIT_W'(ROOT_W - 1);
      end
      OP_SQRT_STEP: begin
        if (cand_fits) begin
          r_q <= cand;
        end
        b_q <= b_q - ROOT_BIT_W'(1);
      end
      OP_LOAD_OUT: begin
        norm_q <= norm_d;
        fidx_q <= j_q;
        last_q <= ((rp_q + CW'(1)) == cnt_q);
        dz_q   <= (var_rd == '0);
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  assign sts_o.div_busy  = div_busy;
  assign sts_o.i_last    = ((i_q + CW'(1)) == n_q);
  assign sts_o.j_last    = (({1'b0, j_q} + DIMS_W'(1)) == dims_eff);
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.refit     = refit_q;
  assign sts_o.rp_valid  = (rp_q < cnt_q);
  assign sts_o.var_zero  = (var_rd == '0);
  assign sts_o.sqrt_last = (b_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign norm_value_o    = norm_q;
  assign feature_index_o = fidx_q;
  assign last_value_o    = last_q;
  assign div_zero_o      = dz_q;

endmodule

// ===== rtl/fsu_ctrl.sv =====
// Controller: command decode and sequencing of the finish and read operations.
module fsu_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [fsu_pkg::CMD_W-1:0] cmd_i,
  output logic                      in_stall_o,
  input  fsu_pkg::fsu_sts_t         sts_i,
  output fsu_pkg::fsu_cmd_t         cmd_o
);
  import fsu_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_FIN_DIV   = 5'd1;
  localparam logic [4:0] S_FIN_WAIT  = 5'd2;
  localparam logic [4:0] S_FIN_N     = 5'd3;
  localparam logic [4:0] S_FIN_CHK   = 5'd4;
  localparam logic [4:0] S_SUM_INIT  = 5'd5;
  localparam logic [4:0] S_SUM_RD    = 5'd6;
  localparam logic [4:0] S_SUM_ACC   = 5'd7;
  localparam logic [4:0] S_MEAN_DIV  = 5'd8;
  localparam logic [4:0] S_MEAN_WAIT = 5'd9;
  localparam logic [4:0] S_MEAN_TAKE = 5'd10;
  localparam logic [4:0] S_SQ_INIT   = 5'd11;
  localparam logic [4:0] S_SQ_RD     = 5'd12;
  localparam logic [4:0] S_SQ_DIF    = 5'd13;
  localparam logic [4:0] S_SQ_MUL    = 5'd14;
  localparam logic [4:0] S_SQ_ACC    = 5'd15;
  localparam logic [4:0] S_VAR_DIV   = 5'd16;
  localparam logic [4:0] S_VAR_WAIT  = 5'd17;
  localparam logic [4:0] S_VAR_TAKE  = 5'd18;
  localparam logic [4:0] S_FIN_DONE  = 5'd19;
  localparam logic [4:0] S_RD_DIV    = 5'd20;
  localparam logic [4:0] S_RD_WAIT   = 5'd21;
  localparam logic [4:0] S_RD_MEM    = 5'd22;
  localparam logic [4:0] S_RD_DIF    = 5'd23;
  localparam logic [4:0] S_RD_CHK    = 5'd24;
  localparam logic [4:0] S_RD_NDIV   = 5'd25;
  localparam logic [4:0] S_RD_NWAIT  = 5'd26;
  localparam logic [4:0] S_RD_SQI    = 5'd27;
  localparam logic [4:0] S_RD_SQRT   = 5'd28;
  localparam logic [4:0] S_RD_OUT    = 5'd29;

  logic [4:0] state_q, state_d;
  logic       ready_q, ready_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_d       = state_q;
    ready_d       = ready_q;
    cmd_o.op      = OP_NONE;
    cmd_o.new_set = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_STORE: begin
              cmd_o.op      = OP_STORE;
              cmd_o.new_set = ready_q;
              ready_d       = 1'b0;
            end
            CMD_FINISH: begin
              state_d = S_FIN_DIV;
            end
            CMD_READ: begin
              if (ready_q && sts_i.rp_valid) begin
                state_d = S_RD_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Whole samples in the set
      S_FIN_DIV: begin
        cmd_o.op = OP_DIV_CNT;
        state_d  = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_FIN_N;
        end
      end
      S_FIN_N: begin
        cmd_o.op = OP_TAKE_N;
        state_d  = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        state_d = (sts_i.refit && !sts_i.n_zero) ? S_SUM_INIT : S_FIN_DONE;
      end
      // Mean of one feature
      S_SUM_INIT: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_SUM_RD;
      end
      S_SUM_RD: begin
        cmd_o.op = OP_RD_WALK;
        state_d  = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.op = OP_ACC_SUM;
        state_d  = sts_i.i_last ? S_MEAN_DIV : S_SUM_RD;
      end
      S_MEAN_DIV: begin
        cmd_o.op = OP_DIV_MEAN;
        state_d  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_MEAN_TAKE;
        end
      end
      S_MEAN_TAKE: begin
        cmd_o.op = OP_TAKE_MEAN;
        state_d  = S_SQ_INIT;
      end
      // Variance of one feature
      S_SQ_INIT: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_SQ_RD;
      end
      S_SQ_RD: begin
        cmd_o.op = OP_RD_WALK;
        state_d  = S_SQ_DIF;
      end
      S_SQ_DIF: begin
        cmd_o.op = OP_DIF;
        state_d  = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd_o.op = OP_SQ;
        state_d  = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.op = OP_ACC_SQ;
        state_d  = sts_i.i_last ? S_VAR_DIV : S_SQ_RD;
      end
      S_VAR_DIV: begin
        cmd_o.op = OP_DIV_VAR;
        state_d  = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_VAR_TAKE;
        end
      end
      S_VAR_TAKE: begin
        cmd_o.op = OP_TAKE_VAR;
        state_d  = sts_i.j_last ? S_FIN_DONE : S_SUM_INIT;
      end
      S_FIN_DONE: begin
        cmd_o.op = OP_RP_CLR;
        ready_d  = 1'b1;
        state_d  = S_IDLE;
      end
      // Read: feature index, difference, divide, root
      S_RD_DIV: begin
        cmd_o.op = OP_DIV_MOD;
        state_d  = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_RD_MEM;
        end
      end
      S_RD_MEM: begin
        cmd_o.op = OP_TAKE_MOD;
        state_d  = S_RD_DIF;
      end
      S_RD_DIF: begin
        cmd_o.op = OP_DIF;
        state_d  = S_RD_CHK;
      end
      S_RD_CHK: begin
        cmd_o.op = OP_SQ;
        state_d  = sts_i.var_zero ? S_RD_OUT : S_RD_NDIV;
      end
      S_RD_NDIV: begin
        cmd_o.op = OP_DIV_NORM;
        state_d  = S_RD_NWAIT;
      end
      S_RD_NWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_RD_SQI;
        end
      end
      S_RD_SQI: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = S_RD_SQRT;
      end
      S_RD_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (sts_i.sqrt_last) begin
          state_d = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_LOAD_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

endmodule

// ===== rtl/feature_standardizer_unit.sv =====
// Top level of the z-score feature standardizer.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_stall_o   cmd_i, sample_value_i
//  out      source     out_valid_o/out_stall_i norm_value_o, feature_index_o,
//                                              last_value_o, div_zero_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A read passes twice through the shared divider (feature index, then scaled square
// over variance) and then runs a 16-step root search; with zero variance it skips the
// second divide and the root search. A finish divides the stored count by dims to get
// n whole samples and, when refitting with n above zero, fits each feature's mean and
// variance. Reset clears the statistics, counters and result valid flag; the sample
// memory is not cleared. in_stall_o is high whenever an operation is in progress.
module feature_standardizer_unit #(
  parameter int unsigned MAX_SAMPLES = fsu_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fsu_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [fsu_pkg::DATA_W-1:0] sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fsu_pkg::DATA_W-1:0] norm_value_o,
  output logic [fsu_pkg::FIDX_W-1:0]        feature_index_o,
  output logic                              last_value_o,
  output logic                              div_zero_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [fsu_pkg::DIMS_W-1:0]        cfg_data_i
);
  import fsu_pkg::*;

  fsu_cmd_t cmd;
  fsu_sts_t sts;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  fsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsu_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_value_i  (sample_value_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .norm_value_o    (norm_value_o),
    .feature_index_o (feature_index_o),
    .last_value_o    (last_value_o),
    .div_zero_o      (div_zero_o)
  );

endmodule

// ===== tb/sv/tb_feature_standardizer_unit.sv =====
// Self-checking testbench for the z-score feature standardizer unit.
module tb_feature_standardizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fsu_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_SAMPLES_DEF * MAX_DIMS;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct {
    logic signed [DATA_W-1:0] norm;
    logic [FIDX_W-1:0]        fidx;
    logic                     last;
    logic                     dz;
  } norm_result_t;

  // Predicts normalized reads and checks the block's results against them
  class zscore_scoreboard;
    logic [DATA_W-1:0] samples [STORE_DEPTH];
    int                mean_q [MAX_DIMS];
    longint unsigned   var_q [MAX_DIMS];
    int unsigned       count;
    int unsigned       rd_ptr;
    bit                set_ready;
    bit                refit_on;
    logic [DIMS_W-1:0] dims_raw;
    norm_result_t      expected_norms[$];
    int unsigned       mismatches;

    function new();
      foreach (mean_q[k]) begin
        mean_q[k] = 0;
        var_q[k] = 0;
      end
      count = 0;
      rd_ptr = 0;
      set_ready = 0;
      refit_on = 1;
      dims_raw = 5'd2;
      mismatches = 0;
    endfunction

    function int unsigned eff_dims();
      if (dims_raw == 0) return 1;
      if (dims_raw > MAX_DIMS) return MAX_DIMS;
      return dims_raw;
    endfunction

    function void write_reg(logic idx, logic [DIMS_W-1:0] data);
      if (idx == REG_REFIT) refit_on = data[0];
      else dims_raw = data;
    endfunction

    // Mean rounded half away from zero, variance rounded half up and saturated
    function void fit_stats(int unsigned dims, int unsigned n);
      longint sum;
      longint unsigned mag, sq, var_v, a;
      longint d;
      for (int unsigned j = 0; j < dims; j++) begin
        sum = 0;
        sq = 0;
        for (int unsigned i = 0; i < n; i++) sum += $signed(samples[i * dims + j]);
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + n / 2) / n;
        mean_q[j] = (sum < 0) ? -int'(mag) : int'(mag);
        for (int unsigned i = 0; i < n; i++) begin
          d = longint'($signed(samples[i * dims + j])) - mean_q[j];
          a = (d < 0) ? -d : d;
          sq += a * a;
        end
        var_v = (sq + n / 2) / n;
        var_q[j] = (var_v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : var_v;
      end
    endfunction

    // Exact rounded |d| * 4096 / sqrt(v) by searching odd squares
    function logic signed [DATA_W-1:0] scale(int d, longint unsigned v);
      longint unsigned a, t, lo, hi, mid, o;
      a = longint'((d < 0) ? -d : d) * 64'd4096;
      t = (4 * a * a) / v;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        o = 2 * mid - 1;
        if (o * o <= t) lo = mid;
        else hi = mid - 1;
      end
      if (d < 0) return 16'(-lo);
      return (lo > 32767) ? 16'sd32767 : 16'(lo);
    endfunction

    function void take_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
      int unsigned dims, n, j;
      norm_result_t r;
      dims = eff_dims();
      case (cmd)
        CMD_STORE: begin
          if (set_ready) begin
            set_ready = 0;
            count = 0;
            rd_ptr = 0;
          end
          if (count < STORE_DEPTH) begin
            samples[count] = val;
            count++;
          end
        end
        CMD_FINISH: begin
          n = count / dims;
          count = n * dims;
          if (refit_on && n > 0) fit_stats(dims, n);
          rd_ptr = 0;
          set_ready = 1;
        end
        CMD_READ: begin
          if (set_ready && rd_ptr < count) begin
            j = rd_ptr % dims;
            r.fidx = j[FIDX_W-1:0];
            r.last = (rd_ptr + 1 == count);
            r.dz = (var_q[j] == 0);
            r.norm = r.dz ? '0
                          : scale($signed(samples[rd_ptr]) - mean_q[j], var_q[j]);
            expected_norms = {expected_norms, r};
            rd_ptr++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(norm_result_t got);
      norm_result_t exp_r;
      if (expected_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: norm=%0d fidx=%0d last=%0b dz=%0b",
                   got.norm, got.fidx, got.last, got.dz);
        return;
      end
      exp_r = expected_norms.pop_front();
      if (got.norm !== exp_r.norm || got.fidx !== exp_r.fidx ||
          got.last !== exp_r.last || got.dz !== exp_r.dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b (norm/fidx/last/dz)",
                   exp_r.norm, exp_r.fidx, exp_r.last, exp_r.dz,
                   got.norm, got.fidx, got.last, got.dz);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         cmd_i;
  logic signed [DATA_W-1:0] sample_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] norm_value_o;
  logic [FIDX_W-1:0]        feature_index_o;
  logic                     last_value_o;
  logic                     div_zero_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic                     cfg_index_i;
  logic [DIMS_W-1:0]        cfg_data_i;

  feature_standardizer_unit DUT (.*);

  zscore_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned out_hold = 0;
  bit          no_gaps = 0;

  // Per-set shape of the generated feature values
  bit                flat_feat [MAX_DIMS];
  logic [DATA_W-1:0] flat_val [MAX_DIMS];
  bit                outlier_set = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Check each result transaction and draw the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{norm: norm_value_o, fidx: feature_index_o,
                        last: last_value_o, dz: div_zero_o});
      out_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold != 0);
  end

  function automatic int unsigned idle_gap();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  // Drive one input transaction and hold it until accepted
  task automatic send(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val = '0);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    sample_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_item(cmd, val);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  // Hold off input until every expected result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_norms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DIMS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(bit refit, logic [DIMS_W-1:0] dims);
    drain();
    write_reg(REG_REFIT, {4'($urandom_range(0, 15)), refit});
    write_reg(REG_DIMS, dims);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(int unsigned k);
    if (flat_feat[k]) return flat_val[k];
    if (outlier_set) begin
      if ($urandom_range(0, 60) != 0) return flat_val[k];
      return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Store n whole samples plus a partial one, finish, then read back
  task automatic run_set(int unsigned n, int unsigned partial, int unsigned reads, bit noisy);
    int unsigned dims;
    dims = sb.eff_dims();
    for (int unsigned k = 0; k < MAX_DIMS; k++) begin
      flat_feat[k] = ($urandom_range(0, 4) == 0);
      flat_val[k] = outlier_set ? 16'($urandom_range(0, 255)) : 16'($urandom);
    end
    for (int unsigned e = 0; e < n * dims + partial; e++) begin
      if (noisy && $urandom_range(0, 25) == 0)
        send($urandom_range(0, 1) ? CMD_NOP : CMD_READ);
      send(CMD_STORE, pick_value(e % dims));
    end
    send(CMD_FINISH);
    for (int unsigned r = 0; r < reads; r++) begin
      if (noisy && $urandom_range(0, 30) == 0) send(CMD_NOP);
      send(CMD_READ);
    end
  endtask

  initial begin
    logic [DIMS_W-1:0] dims_pick;
    int unsigned n;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_STORE;
    sample_value_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_REFIT;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Read before any finish, ignored command, extremes with a partial sample
    send(CMD_READ);
    send(CMD_NOP);
    send(CMD_STORE, 16'h7FFF);
    send(CMD_STORE, 16'h8000);
    send(CMD_STORE, 16'h0000);
    send(CMD_STORE, 16'h0000);
    send(CMD_STORE, 16'h0005);
    send(CMD_FINISH);
    repeat (5) send(CMD_READ);

    // Reuse kept statistics with dims of zero acting as one
    configure(1'b0, 5'd0);
    send(CMD_STORE, 16'h0100);
    send(CMD_STORE, 16'hFF00);
    send(CMD_STORE, 16'h4000);
    send(CMD_FINISH);
    repeat (4) send(CMD_READ);

    // Dims above the limit, one sample so every variance is zero
    configure(1'b1, 5'd31);
    for (int unsigned k = 0; k < MAX_DIMS; k++) send(CMD_STORE, 16'(k * 300));
    send(CMD_FINISH);
    repeat (2) send(CMD_READ);

    // Random sets across configurations
    items_sent = 0;
    while (items_sent < 1350) begin
      case ($urandom_range(0, 9))
        0: dims_pick = 5'd0;
        1: dims_pick = 5'($urandom_range(17, 30));
        2: dims_pick = 5'd31;
        3: dims_pick = 5'd16;
        default: dims_pick = 5'($urandom_range(1, 16));
      endcase
      outlier_set = ($urandom_range(0, 7) == 0);
      if (outlier_set) begin
        dims_pick = 5'd1;
        n = $urandom_range(40, 100);
      end else begin
        n = $urandom_range(0, 6);
      end
      configure($urandom_range(0, 3) != 0, dims_pick);
      no_gaps = ($urandom_range(0, 5) == 0);
      run_set(n, $urandom_range(0, sb.eff_dims() - 1),
              outlier_set ? $urandom_range(1, 12)
                          : n * sb.eff_dims() + $urandom_range(0, 2) + 1 -
                            ($urandom_range(0, 3) == 0 ? $urandom_range(0, n) : 0),
              1'b1);
    end
    outlier_set = 0;

    drain();
    if (sb.mismatches == 0 && sb.expected_norms.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
